### hw/rtl/pva_pkg.sv
// Shared types and constants for the priority voice allocator.
`default_nettype none

package pva_pkg;

	// Carried index and count widths cover the largest supported row (32 channels).
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;

	// Request type codes on the input transaction.
	localparam logic [2:0] REQ_NOTE_ON     = 3'd0;
	localparam logic [2:0] REQ_NOTE_OFF    = 3'd1;
	localparam logic [2:0] REQ_TRACK_OFF   = 3'd2;
	localparam logic [2:0] REQ_SOUND_OFF   = 3'd3;
	localparam logic [2:0] REQ_CHAN_FINISH = 3'd4;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_NOTE_ON,
		OP_NOTE_OFF,
		OP_TRACK_OFF,
		OP_SOUND_OFF,
		OP_FINISH
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [3:0] track;
		logic [7:0] note_key;
		logic [7:0] req_priority;
		logic [3:0] chan_sel;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic [3:0] granted_chan;
		logic       was_stolen;
		logic [3:0] released_count;
	} rsp_t;

	// Request as broadcast to every cell during a scan.
	typedef struct packed {
		op_t        op;
		logic [3:0] track;
		logic [7:0] note_key;
		logic [7:0] req_priority;
		logic [3:0] chan_sel;
		logic [3:0] active_channels;
	} bcast_t;

	// Running scan state handed from cell to cell along with the token.
	typedef struct packed {
		logic             tok;
		logic             pick_found;
		logic [IDX_W-1:0] pick;
		logic             best_found;
		logic [IDX_W-1:0] best;
		logic             have_rel;
		logic [7:0]       bp;
		logic [3:0]       bt;
		logic [CNT_W-1:0] count;
	} carry_t;

	// Note-on grant written into the selected cell.
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] chan;
		logic [7:0]       priority_v;
		logic [3:0]       owner;
		logic [7:0]       key;
	} commit_t;

endpackage

`default_nettype wire

### hw/rtl/pva_cell.sv
// One voice channel cell: holds the channel state and passes the scan carry on.
`default_nettype none

module pva_cell import pva_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire     clk,
	input  wire     arst_n,
	input  bcast_t  bcast,
	input  carry_t  carry_in,
	input  commit_t commit,
	output carry_t  carry_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic       on_q;
	logic       rel_q;
	logic [7:0] pri_q;
	logic [3:0] own_q;
	logic [7:0] key_q;

	logic       on_d;
	logic       rel_d;
	logic       wr_own;
	logic       rb;
	logic       in_scope;
	carry_t     c;
	carry_t     carry_q;

	always_comb begin
		c        = carry_in;
		on_d     = on_q;
		rel_d    = rel_q;
		rb       = (pri_q < carry_in.bp) || ((pri_q == carry_in.bp) && (own_q >= carry_in.bt));
		in_scope = ({1'b0, bcast.active_channels} > MY_IDX);
		wr_own   = commit.en && (commit.chan == MY_IDX);
		if (carry_in.tok) begin
			unique case (bcast.op)
				OP_NOTE_ON: begin
					if (in_scope && !carry_in.pick_found) begin
						if (!on_q) begin
							c.pick_found = 1'b1;
							c.pick       = MY_IDX;
						end else if (rel_q) begin
							if (!carry_in.have_rel || rb) begin
								c.have_rel   = 1'b1;
								c.best_found = 1'b1;
								c.best       = MY_IDX;
								c.bp         = pri_q;
								c.bt         = own_q;
							end
						end else if (!carry_in.have_rel && rb) begin
							c.best_found = 1'b1;
							c.best       = MY_IDX;
							c.bp         = pri_q;
							c.bt         = own_q;
						end
					end
				end
				OP_NOTE_OFF: begin
					if (on_q && !rel_q && (own_q == bcast.track) && (key_q == bcast.note_key)) begin
						rel_d   = 1'b1;
						c.count = carry_in.count + CNT_W'(1);
					end
				end
				OP_TRACK_OFF: begin
					if (on_q && (own_q == bcast.track)) begin
						if (!rel_q) begin
							c.count = carry_in.count + CNT_W'(1);
						end
						rel_d = 1'b1;
					end
				end
				OP_SOUND_OFF: begin
					if (on_q) begin
						c.count = carry_in.count + CNT_W'(1);
					end
					on_d  = 1'b0;
					rel_d = 1'b0;
				end
				OP_FINISH: begin
					if ({1'b0, bcast.chan_sel} == MY_IDX) begin
						if (on_q) begin
							c.count = carry_in.count + CNT_W'(1);
						end
						on_d  = 1'b0;
						rel_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		if (wr_own) begin
			on_d  = 1'b1;
			rel_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= 1'b0;
			rel_q   <= 1'b0;
			carry_q <= '0;
		end else begin
			on_q    <= on_d;
			rel_q   <= rel_d;
			carry_q <= c;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_own) begin
			pri_q <= commit.priority_v;
			own_q <= commit.owner;
			key_q <= commit.key;
		end
	end

	assign carry_out = carry_q;

endmodule

`default_nettype wire

### hw/rtl/priority_voice_allocator.sv
// Top level of the priority voice allocator: request control, cell row, result register.
`default_nettype none

// Priority voice allocator. CHANNELS voice channels live in a row of cells,
// each holding its on/releasing flags, priority, owning track and key. An
// accepted request transaction is latched and broadcast to the row, and a
// single token walks the row one cell per cycle, carrying the running
// note-on search (first free channel, else best releasing channel, else best
// stealable active channel) and the count of channels released or cleared.
// Note-off, track-off, sound-off and channel-finished update each cell as the
// token passes it; a note-on grant is written into the chosen cell when the
// token leaves the last cell. Every request gives exactly one response
// transaction. A new request is accepted only after the token has walked
// the row and the result has moved on to the output register, so one
// request is in flight at a time. The response sits in an output
// register, so a pending response may wait on rsp_stall while the next
// request is accepted and scanned. active_channels (reset 5) limits which
// channels note-on may use; write it only while no request is in flight.
// Request tracks at or above TRACKS make note-on, note-off and track-off
// no-ops; unknown request types are no-ops with an all-zero response.
module priority_voice_allocator import pva_pkg::*; #(
	parameter int CHANNELS = 12,
	parameter int TRACKS   = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  wire        rsp_stall,
	output rsp_t       rsp,
	input  wire        cfg_wr_en,
	input  wire  [3:0] cfg_wr_data
);

	localparam logic [3:0] ACTIVE_RESET = 4'd5;

	state_t  state_q;
	state_t  state_d;
	logic    start_q;
	logic    [3:0] active_q;
	bcast_t  bc_q;
	rsp_t    res_q;
	rsp_t    rsp_q;
	logic    rsp_valid_q;

	logic    accept;
	logic    load_out;
	logic    grant;
	logic    track_bad;
	op_t     op_dec;
	bcast_t  bc_d;
	commit_t commit;
	rsp_t    res_d;
	carry_t  end_c;
	carry_t  chain [CHANNELS+1];
	logic    [CHANNELS:0] tok_vec;

	// Request decode: out-of-range tracks turn the track-based requests into no-ops.
	always_comb begin
		track_bad = ({2'b00, req.track} >= 6'(TRACKS));
		unique case (req.req_type)
			REQ_NOTE_ON:     op_dec = track_bad ? OP_NONE : OP_NOTE_ON;
			REQ_NOTE_OFF:    op_dec = track_bad ? OP_NONE : OP_NOTE_OFF;
			REQ_TRACK_OFF:   op_dec = track_bad ? OP_NONE : OP_TRACK_OFF;
			REQ_SOUND_OFF:   op_dec = OP_SOUND_OFF;
			REQ_CHAN_FINISH: op_dec = OP_FINISH;
			default:         op_dec = OP_NONE;
		endcase
		bc_d.op              = op_dec;
		bc_d.track           = req.track;
		bc_d.note_key        = req.note_key;
		bc_d.req_priority    = req.req_priority;
		bc_d.chan_sel        = req.chan_sel;
		bc_d.active_channels = active_q;
	end

	// Token enters the row the cycle after acceptance.
	always_comb begin
		chain[0]     = '0;
		chain[0].tok = start_q;
		chain[0].bp  = bc_q.req_priority;
		chain[0].bt  = bc_q.track;
	end

	for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
		pva_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bcast    (bc_q),
			.carry_in (chain[i]),
			.commit   (commit),
			.carry_out(chain[i+1])
		);
	end

	always_comb begin
		for (int i = 0; i <= CHANNELS; i++) begin
			tok_vec[i] = chain[i].tok;
		end
	end

	assign end_c = chain[CHANNELS];

	// Wrap-up when the token leaves the last cell: pick the grant and build the response.
	always_comb begin
		grant = (bc_q.op == OP_NOTE_ON) &&
			(end_c.pick_found ||
			 (end_c.best_found && (end_c.have_rel || (bc_q.req_priority >= end_c.bp))));
		commit.en         = end_c.tok && grant;
		commit.chan       = end_c.pick_found ? end_c.pick : end_c.best;
		commit.priority_v = bc_q.req_priority;
		commit.owner      = bc_q.track;
		commit.key        = bc_q.note_key;
		res_d             = '0;
		if (grant) begin
			res_d.granted      = 1'b1;
			res_d.granted_chan = commit.chan[3:0];
			res_d.was_stolen   = !end_c.pick_found;
		end else begin
			res_d.released_count = (end_c.count > CNT_W'(15)) ? 4'hF : end_c.count[3:0];
		end
	end

	assign accept   = req_valid && !req_stall;
	assign load_out = (state_q == ST_EMIT) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (end_c.tok) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= 1'b0;
			active_q    <= ACTIVE_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (cfg_wr_en) begin
				active_q <= cfg_wr_data;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bc_q <= bc_d;
		end
		if (end_c.tok) begin
			res_q <= res_d;
		end
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Only one token may be in the row at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vec) <= 1)
		else $error("more than one scan token in the cell row");

	// The token only leaves the row while a scan is in progress.
	a_end_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		end_c.tok |-> (state_q == ST_SCAN))
		else $error("scan token left the row outside a scan");

	// An accepted transaction launches the token into the row.
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (start_q && (state_q == ST_SCAN)))
		else $error("accepted request did not start a scan");

	// A grant never reports released channels, and stolen implies granted.
	a_rsp_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((!rsp.granted || (rsp.released_count == 4'd0)) &&
			(!rsp.was_stolen || rsp.granted)))
		else $error("inconsistent response fields");

endmodule

`default_nettype wire

### tb/sv/priority_voice_allocator_checker.sv
// Checker for the priority voice allocator: predicts each response and compares it.
import pva_pkg::*;

module priority_voice_allocator_checker #(
	parameter int CHANNELS = 12,
	parameter int TRACKS   = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        req_valid,
	input  wire        req_stall,
	input  req_t       req,
	input  wire        rsp_valid,
	input  wire        rsp_stall,
	input  rsp_t       rsp,
	input  wire        cfg_wr_en,
	input  wire  [3:0] cfg_wr_data,
	output int         fail_count,
	output int         pending
);

	localparam logic [3:0] ACTIVE_RESET = 4'd5;
	localparam logic [3:0] COUNT_MAX    = 4'd15;
	localparam int         PRINT_CAP    = 200;

	// Shadow copy of the channel table and the one register.
	logic [3:0] active_chans;
	logic       chan_on  [CHANNELS];
	logic       chan_rel [CHANNELS];
	logic [7:0] chan_pri [CHANNELS];
	logic [3:0] chan_trk [CHANNELS];
	logic [7:0] chan_key [CHANNELS];

	rsp_t alloc_due_q[$];
	rsp_t want;
	int   fails;

	// Channel i ranks at or before the running best (lower priority, then higher track).
	function automatic bit outranks(int i, logic [7:0] bp, logic [3:0] bt);
		return chan_pri[i] < bp || (chan_pri[i] == bp && chan_trk[i] >= bt);
	endfunction

	function automatic rsp_t predict_voice(req_t r);
		rsp_t       o;
		int         lim;
		int         pick;
		int         best;
		bit         have_rel;
		logic [7:0] bp;
		logic [3:0] bt;
		int         cnt;
		o        = '0;
		cnt      = 0;
		pick     = -1;
		best     = -1;
		have_rel = 1'b0;
		bp       = r.req_priority;
		bt       = r.track;
		lim      = (active_chans < CHANNELS) ? int'(active_chans) : CHANNELS;
		if (r.req_type <= REQ_TRACK_OFF && int'(r.track) >= TRACKS)
			return o;
		case (r.req_type)
			REQ_NOTE_ON: begin
				for (int i = 0; i < lim && pick < 0; i++) begin
					if (!chan_on[i]) begin
						pick = i;
					end else if (chan_rel[i]) begin
						if (!have_rel || outranks(i, bp, bt)) begin
							have_rel = 1'b1;
							bp       = chan_pri[i];
							bt       = chan_trk[i];
							best     = i;
						end
					end else if (!have_rel && outranks(i, bp, bt)) begin
						bp   = chan_pri[i];
						bt   = chan_trk[i];
						best = i;
					end
				end
				// releasing channels go regardless; active ones only if not outranked
				if (pick < 0 && best >= 0 && (have_rel || r.req_priority >= bp))
					pick = best;
				if (pick >= 0) begin
					o.granted       = 1'b1;
					o.granted_chan  = 4'(pick);
					o.was_stolen    = chan_on[pick];
					chan_on[pick]   = 1'b1;
					chan_rel[pick]  = 1'b0;
					chan_pri[pick]  = r.req_priority;
					chan_trk[pick]  = r.track;
					chan_key[pick]  = r.note_key;
				end
			end
			REQ_NOTE_OFF: begin
				for (int i = 0; i < CHANNELS; i++)
					if (chan_on[i] && !chan_rel[i] && chan_trk[i] == r.track &&
					    chan_key[i] == r.note_key) begin
						chan_rel[i] = 1'b1;
						cnt++;
					end
			end
			REQ_TRACK_OFF: begin
				for (int i = 0; i < CHANNELS; i++)
					if (chan_on[i] && chan_trk[i] == r.track) begin
						if (!chan_rel[i])
							cnt++;
						chan_rel[i] = 1'b1;
					end
			end
			REQ_SOUND_OFF: begin
				for (int i = 0; i < CHANNELS; i++) begin
					if (chan_on[i])
						cnt++;
					chan_on[i]  = 1'b0;
					chan_rel[i] = 1'b0;
				end
			end
			REQ_CHAN_FINISH: begin
				if (int'(r.chan_sel) < CHANNELS) begin
					if (chan_on[r.chan_sel])
						cnt = 1;
					chan_on[r.chan_sel]  = 1'b0;
					chan_rel[r.chan_sel] = 1'b0;
				end
			end
			default: ;
		endcase
		o.released_count = (cnt > int'(COUNT_MAX)) ? COUNT_MAX : 4'(cnt);
		return o;
	endfunction

	task automatic check_field(input string name, input int exp, input int act);
		if (exp != act) begin
			fails++;
			if (fails <= PRINT_CAP)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_chans = ACTIVE_RESET;
			for (int i = 0; i < CHANNELS; i++) begin
				chan_on[i]  = 1'b0;
				chan_rel[i] = 1'b0;
				chan_pri[i] = '0;
				chan_trk[i] = '0;
				chan_key[i] = '0;
			end
			alloc_due_q.delete();
			fails = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en)
				active_chans = cfg_wr_data;
			// response first: it always belongs to an earlier request
			if (rsp_valid && !rsp_stall) begin
				if (alloc_due_q.size() == 0) begin
					fails++;
					if (fails <= PRINT_CAP)
						$display("%0t: unexpected response, expected none, actual %h",
							$time, rsp);
				end else begin
					want = alloc_due_q.pop_front();
					check_field("granted", int'(want.granted), int'(rsp.granted));
					check_field("granted_chan", int'(want.granted_chan),
						int'(rsp.granted_chan));
					check_field("was_stolen", int'(want.was_stolen), int'(rsp.was_stolen));
					check_field("released_count", int'(want.released_count),
						int'(rsp.released_count));
				end
			end
			if (req_valid && !req_stall)
				alloc_due_q.push_back(predict_voice(req));
			fail_count <= fails;
			pending    <= alloc_due_q.size();
		end
	end

endmodule

### tb/sv/priority_voice_allocator_tb.sv
// Testbench top for the priority voice allocator: stimulus, handshakes, watchdog, verdict.
import pva_pkg::*;

module priority_voice_allocator_tb;

	localparam int CHANNELS       = 12;
	localparam int TRACKS         = 16;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 116;
	localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
	localparam int DRAIN_CYCLES   = 20;    // idle time before the verdict
	localparam int WATCHDOG_LIMIT = 2000;  // idle cycles before giving up

	// request codes 5..7 are undefined; the block must ignore them
	localparam logic [2:0] REQ_UNUSED_LO = REQ_CHAN_FINISH + 3'd1;
	localparam logic [2:0] REQ_UNUSED_HI = 3'h7;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_t       rsp;
	logic       cfg_wr_en;
	logic [3:0] cfg_wr_data;

	int fail_count;
	int pending;

	// hold_ask: stimulus asks the receiver for one long hold-off.
	// calm: last phase, no idling on either side.
	logic hold_ask;
	logic calm;
	bit   hold_done;
	int   idle_cycles;

	priority_voice_allocator #(
		.CHANNELS(CHANNELS),
		.TRACKS  (TRACKS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	priority_voice_allocator_checker #(
		.CHANNELS(CHANNELS),
		.TRACKS  (TRACKS)
	) alloc_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Watchdog: any cycle with no accepted transaction on either channel counts.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("priority_voice_allocator_tb failed");
				$finish;
			end
		end
	end

	// Response side. One nonblocking write per loop pass, each pass starting at
	// a clock edge. Random stall bursts, one long hold-off on request so the
	// block backs up into req_stall, nothing once calm.
	initial begin
		rsp_stall = 1'b0;
		hold_done = 1'b0;
		forever begin
			if (hold_ask && !hold_done) begin
				rsp_stall <= 1'b1;
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	function automatic req_t mk_req(logic [2:0] kind, logic [3:0] trk, logic [7:0] key,
	                                logic [7:0] pri, logic [3:0] sel);
		req_t r;
		r.req_type     = kind;
		r.track        = trk;
		r.note_key     = key;
		r.req_priority = pri;
		r.chan_sel     = sel;
		return r;
	endfunction

	// Random request. Tracks, keys and priorities mostly come from small pools
	// so note-offs hit live notes and priority/track ties are common; a quarter
	// of the time each field takes its full range.
	function automatic req_t rand_req();
		req_t r;
		int   pick;
		pick           = $urandom_range(0, 99);
		r.track        = 4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
		                                                : $urandom_range(0, 3));
		r.note_key     = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
		                                                : $urandom_range(0, 3));
		r.req_priority = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
		                                                : $urandom_range(0, 3) * 85);
		r.chan_sel     = 4'($urandom_range(0, 15));
		if (pick < 45)
			r.req_type = REQ_NOTE_ON;
		else if (pick < 65)
			r.req_type = REQ_NOTE_OFF;
		else if (pick < 72)
			r.req_type = REQ_TRACK_OFF;
		else if (pick < 75)
			r.req_type = REQ_SOUND_OFF;
		else if (pick < 94)
			r.req_type = REQ_CHAN_FINISH;
		else
			r.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
		return r;
	endfunction

	// Offer one request transaction; returns at the edge where it is taken.
	// valid stays high into the next call, so back-to-back offers need no gap.
	task automatic offer(input req_t item);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
	endtask

	// Stop offering and wait until every predicted response has come back.
	// pending is published by the checker with a nonblocking write at each edge.
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// active_channels is only written with nothing in flight.
	task automatic write_active(input logic [3:0] value);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		logic [3:0] phase_cfg [PHASES];
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		hold_ask    = 1'b0;
		calm        = 1'b0;
		idle_cycles = 0;
		// extremes first: full table, single channel, out-of-range high, zero
		phase_cfg   = '{4'd12, 4'd1, 4'd15, 4'd0, 4'd7, 4'd3, 4'd9, 4'd12};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset value of five usable channels.
		// Fill channels 0..4 with extreme tracks, keys and priorities.
		offer(mk_req(REQ_NOTE_ON, 4'd0, 8'h00, 8'd0, 4'd0));
		offer(mk_req(REQ_NOTE_ON, 4'd15, 8'hFF, 8'd255, 4'd0));
		offer(mk_req(REQ_NOTE_ON, 4'd3, 8'd10, 8'd100, 4'd0));
		offer(mk_req(REQ_NOTE_ON, 4'd3, 8'd11, 8'd100, 4'd0));
		offer(mk_req(REQ_NOTE_ON, 4'd7, 8'd12, 8'd50, 4'd0));
		// table full: steal the lowest-priority active channel (ch0)
		offer(mk_req(REQ_NOTE_ON, 4'd2, 8'd20, 8'd50, 4'd0));
		// equal priority, every holder's track below ours: refused
		offer(mk_req(REQ_NOTE_ON, 4'd9, 8'd30, 8'd50, 4'd0));
		// equal priority, holder track 7 >= 5: steal ch4
		offer(mk_req(REQ_NOTE_ON, 4'd5, 8'd31, 8'd50, 4'd0));
		// low priority against a full table: refused
		offer(mk_req(REQ_NOTE_ON, 4'd1, 8'd32, 8'd0, 4'd0));
		// note off, then again on an already releasing note
		offer(mk_req(REQ_NOTE_OFF, 4'd3, 8'd10, 8'd0, 4'd0));
		offer(mk_req(REQ_NOTE_OFF, 4'd3, 8'd10, 8'd0, 4'd0));
		// releasing channel taken even at priority zero
		offer(mk_req(REQ_NOTE_ON, 4'd0, 8'd40, 8'd0, 4'd0));
		// track off, then again: releasing channels are not counted twice
		offer(mk_req(REQ_TRACK_OFF, 4'd3, 8'd0, 8'd0, 4'd0));
		offer(mk_req(REQ_TRACK_OFF, 4'd3, 8'd0, 8'd0, 4'd0));
		// finish a live channel, the same now-off channel, and an index past the table
		offer(mk_req(REQ_CHAN_FINISH, 4'd0, 8'd0, 8'd0, 4'd3));
		offer(mk_req(REQ_CHAN_FINISH, 4'd0, 8'd0, 8'd0, 4'd3));
		offer(mk_req(REQ_CHAN_FINISH, 4'd15, 8'hFF, 8'hFF, 4'd15));
		// undefined request codes with every field bit set
		offer(mk_req(REQ_UNUSED_LO, 4'd15, 8'hFF, 8'hFF, 4'd15));
		offer(mk_req(REQ_UNUSED_LO + 3'd1, 4'd15, 8'hFF, 8'hFF, 4'd15));
		offer(mk_req(REQ_UNUSED_HI, 4'd15, 8'hFF, 8'hFF, 4'd15));
		// note off on the top track and key, then sound off twice
		offer(mk_req(REQ_NOTE_OFF, 4'd15, 8'hFF, 8'd0, 4'd0));
		offer(mk_req(REQ_SOUND_OFF, 4'd0, 8'd0, 8'd0, 4'd0));
		offer(mk_req(REQ_SOUND_OFF, 4'd0, 8'd0, 8'd0, 4'd0));
		drain();

		// Random phases, one active_channels setting each.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_active(phase_cfg[ph]);
			if (ph == PHASES - 1)
				calm <= 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 0 && n == PHASE_ITEMS / 3)
					hold_ask <= 1'b1;
				offer(rand_req());
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("priority_voice_allocator_tb passed");
		else
			$display("priority_voice_allocator_tb failed");
		$finish;
	end

endmodule
